FILE: rtl/core/csvtok_pkg.sv
`timescale 1ns / 1ps

package csvtok_pkg;

  // Token kinds on the result channel
  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;

  // Quote tracking codes
  localparam logic [1:0] QM_OUTSIDE = 2'd0;
  localparam logic [1:0] QM_INSIDE  = 2'd1;
  localparam logic [1:0] QM_PENDING = 2'd2;

  // Character constants
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Output buffer depth
  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
  } token_t;

endpackage

FILE: rtl/core/csvtok_step.sv
`timescale 1ns / 1ps

// Per-byte tokenizer decision and the parser state it updates.
module csvtok_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           byte_q,
  input  logic                 eoi_q,
  input  logic [7:0]           delim,
  output csvtok_pkg::token_t   tok
);

  logic [1:0] quote_mode;
  logic [1:0] quote_mode_next;
  logic       after_line_end;
  logic       after_line_end_next;
  logic       record_open;
  logic       record_open_next;

  logic       do_outside;
  logic       swallow;

  // Decide result and next state for the byte in the input register
  always_comb begin
    quote_mode_next     = quote_mode;
    after_line_end_next = after_line_end;
    record_open_next    = record_open;
    tok                 = '0;
    do_outside          = 1'b0;
    swallow             = after_line_end && (byte_q == csvtok_pkg::CH_LF);

    if (eoi_q) begin
      // Flush: close the open record, clear all state
      quote_mode_next     = csvtok_pkg::QM_OUTSIDE;
      after_line_end_next = 1'b0;
      record_open_next    = 1'b0;
      if (record_open) begin
        tok.valid = 1'b1;
        tok.kind  = csvtok_pkg::KIND_RECORD_END;
      end
    end else begin
      after_line_end_next = 1'b0;
      if (!swallow) begin
        if (quote_mode == csvtok_pkg::QM_PENDING) begin
          // Resolve the pending quote: doubled quote or closing quote
          if (byte_q == csvtok_pkg::CH_QUOTE) begin
            quote_mode_next  = csvtok_pkg::QM_INSIDE;
            record_open_next = 1'b1;
            tok.valid        = 1'b1;
            tok.kind         = csvtok_pkg::KIND_DATA;
            tok.data         = csvtok_pkg::CH_QUOTE;
          end else begin
            quote_mode_next = csvtok_pkg::QM_OUTSIDE;
            do_outside      = 1'b1;
          end
        end else if (quote_mode != csvtok_pkg::QM_OUTSIDE) begin
          // Inside quotes: hold a quote for lookahead, pass anything else
          record_open_next = 1'b1;
          if (byte_q == csvtok_pkg::CH_QUOTE) begin
            quote_mode_next = csvtok_pkg::QM_PENDING;
          end else begin
            tok.valid = 1'b1;
            tok.kind  = csvtok_pkg::KIND_DATA;
            tok.data  = byte_q;
          end
        end else begin
          do_outside = 1'b1;
        end

        // Outside-quote handling: quote, delimiter, line end, data
        if (do_outside) begin
          if (byte_q == csvtok_pkg::CH_QUOTE) begin
            quote_mode_next  = csvtok_pkg::QM_INSIDE;
            record_open_next = 1'b1;
          end else if (byte_q == delim) begin
            record_open_next = 1'b1;
            tok.valid        = 1'b1;
            tok.kind         = csvtok_pkg::KIND_FIELD_END;
          end else if (byte_q == csvtok_pkg::CH_CR || byte_q == csvtok_pkg::CH_LF) begin
            after_line_end_next = 1'b1;
            record_open_next    = 1'b0;
            tok.valid           = 1'b1;
            tok.kind            = csvtok_pkg::KIND_RECORD_END;
          end else begin
            record_open_next = 1'b1;
            tok.valid        = 1'b1;
            tok.kind         = csvtok_pkg::KIND_DATA;
            tok.data         = byte_q;
          end
        end
      end
    end
  end

  // Advance parser state when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode     <= csvtok_pkg::QM_OUTSIDE;
      after_line_end <= 1'b0;
      record_open    <= 1'b0;
    end else if (fire) begin
      quote_mode     <= quote_mode_next;
      after_line_end <= after_line_end_next;
      record_open    <= record_open_next;
    end
  end

endmodule

FILE: rtl/core/csvtok_obuf.sv
`timescale 1ns / 1ps

// Small result queue that decouples the tokenizer from the output handshake.
module csvtok_obuf #(
  parameter int DEPTH = csvtok_pkg::OBUF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  csvtok_pkg::token_t   push_tok,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           token_kind,
  output logic [7:0]           data_byte
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [9:0]    entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign space      = (count != CW'(DEPTH));
  assign token_kind = entry[rd_ptr][9:8];
  assign data_byte  = entry[rd_ptr][7:0];

  // Store a result transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {push_tok.kind, push_tok.data};
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/csv_byte_tokenizer_core.sv
`timescale 1ns / 1ps

// Streaming CSV tokenizer: one text byte per input transaction, at most one
// token per byte (data byte, field end, record end). It sustains one byte per
// clock: a byte sits in the input register while the quote/line-end state
// logic decides its token, which then enters a two-entry output queue and is
// offered from there. The input stalls only while the output queue is full.
// A quote inside quotes is resolved by the next byte: a second quote gives a
// literal quote token, any other byte closes the quotes. An input with
// end_of_input set closes an open record and clears all parser state.
// The delimiter register resets to comma and must be written only while idle.
module csv_byte_tokenizer_core #(
  parameter int OBUF_DEPTH = csvtok_pkg::OBUF_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] delimiter_char,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] token_kind,
  output logic [7:0] data_byte
);

  logic               stage_valid;
  logic [7:0]         stage_byte;
  logic               stage_eoi;
  logic [7:0]         delim;
  logic               space;
  logic               fire;
  csvtok_pkg::token_t tok;

  assign cfg_ready = 1'b1;
  assign fire      = stage_valid && space;
  assign in_ready  = !stage_valid || fire;

  // Hold the delimiter setting
  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= csvtok_pkg::CH_COMMA;
    end else if (cfg_valid && cfg_ready) begin
      delim <= delimiter_char;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= byte_in;
      stage_eoi  <= end_of_input;
    end
  end

  csvtok_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .byte_q (stage_byte),
    .eoi_q  (stage_eoi),
    .delim  (delim),
    .tok    (tok)
  );

  csvtok_obuf #(
    .DEPTH (OBUF_DEPTH)
  ) u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire && tok.valid),
    .push_tok   (tok),
    .space      (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .data_byte  (data_byte)
  );

endmodule

FILE: tb/tb_csv_byte_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_csv_byte_tokenizer_core;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_BYTES  = 180;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_PRINTED  = 60;

  typedef struct {
    logic [7:0] text;
    logic       eoi;
  } text_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
  } token_exp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] delimiter_char = csvtok_pkg::CH_COMMA;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] token_kind;
  logic [7:0] data_byte;

  // Parser shadow state and its copy of the delimiter register
  logic [1:0] shadow_quote = csvtok_pkg::QM_OUTSIDE;
  logic       shadow_eol = 1'b0;
  logic       shadow_open = 1'b0;
  logic [7:0] shadow_delim = csvtok_pkg::CH_COMMA;

  text_item_t byte_queue[$];
  token_exp_t expected_tokens[$];
  text_item_t offered_item;
  token_exp_t want_token;
  logic [7:0] phase_delim = csvtok_pkg::CH_COMMA;
  int         queued_bytes = 0;
  int         tokens_seen = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  int         out_hold = 0;
  int         tx_calm = 0;
  int         rx_calm = 0;

  csv_byte_tokenizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .delimiter_char(delimiter_char),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_in       (byte_in),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .data_byte     (data_byte)
  );

  always #5 clk = ~clk;

  // Count mismatches; print only the first few
  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d, token %0d)",
               what, got, want, cycle_count, tokens_seen);
    end
    error_count++;
  endtask

  // Mostly no gap, some short, a few long, with calm stretches of no gaps at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(30, 120);
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void expect_token(logic [1:0] kind, logic [7:0] data);
    token_exp_t t;
    t.kind = kind;
    t.data = (kind == csvtok_pkg::KIND_DATA) ? data : 8'h00;
    expected_tokens = {expected_tokens, t};
  endfunction

  // Byte handling with quotes closed
  function automatic void tokenize_unquoted(logic [7:0] b);
    if (b == csvtok_pkg::CH_QUOTE) begin
      shadow_quote = csvtok_pkg::QM_INSIDE;
      shadow_open = 1'b1;
    end else if (b == shadow_delim) begin
      shadow_open = 1'b1;
      expect_token(csvtok_pkg::KIND_FIELD_END, 8'h00);
    end else if (b == csvtok_pkg::CH_CR || b == csvtok_pkg::CH_LF) begin
      shadow_eol = 1'b1;
      shadow_open = 1'b0;
      expect_token(csvtok_pkg::KIND_RECORD_END, 8'h00);
    end else begin
      shadow_open = 1'b1;
      expect_token(csvtok_pkg::KIND_DATA, b);
    end
  endfunction

  // Advance the shadow parser by one accepted byte
  function automatic void tokenize_byte(text_item_t it);
    if (it.eoi) begin
      if (shadow_open) expect_token(csvtok_pkg::KIND_RECORD_END, 8'h00);
      shadow_quote = csvtok_pkg::QM_OUTSIDE;
      shadow_eol = 1'b0;
      shadow_open = 1'b0;
      return;
    end
    if (shadow_eol) begin
      shadow_eol = 1'b0;
      if (it.text == csvtok_pkg::CH_LF) return;
    end
    if (shadow_quote == csvtok_pkg::QM_PENDING) begin
      if (it.text == csvtok_pkg::CH_QUOTE) begin
        shadow_quote = csvtok_pkg::QM_INSIDE;
        shadow_open = 1'b1;
        expect_token(csvtok_pkg::KIND_DATA, csvtok_pkg::CH_QUOTE);
      end else begin
        shadow_quote = csvtok_pkg::QM_OUTSIDE;
        tokenize_unquoted(it.text);
      end
      return;
    end
    if (shadow_quote != csvtok_pkg::QM_OUTSIDE) begin
      shadow_open = 1'b1;
      if (it.text == csvtok_pkg::CH_QUOTE) shadow_quote = csvtok_pkg::QM_PENDING;
      else expect_token(csvtok_pkg::KIND_DATA, it.text);
      return;
    end
    tokenize_unquoted(it.text);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    text_item_t it;
    it.text = b;
    it.eoi = 1'b0;
    byte_queue = {byte_queue, it};
    queued_bytes++;
  endfunction

  function automatic void push_end(logic [7:0] b);
    text_item_t it;
    it.text = b;
    it.eoi = 1'b1;
    byte_queue = {byte_queue, it};
    queued_bytes++;
  endfunction

  // Field content byte with no structural meaning under the current delimiter
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = rand_byte();
    end while (b == csvtok_pkg::CH_QUOTE || b == phase_delim ||
               b == csvtok_pkg::CH_CR || b == csvtok_pkg::CH_LF);
    return b;
  endfunction

  // Queue one well-formed record with random fields and a random terminator
  function automatic void queue_record();
    int         nfields;
    int         len;
    logic [7:0] b;
    nfields = $urandom_range(1, 5);
    for (int k = 0; k < nfields; k++) begin
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
        push_byte(csvtok_pkg::CH_QUOTE);
        for (int j = 0; j < len; j++) begin
          b = rand_byte();
          push_byte(b);
          if (b == csvtok_pkg::CH_QUOTE) push_byte(csvtok_pkg::CH_QUOTE);
        end
        push_byte(csvtok_pkg::CH_QUOTE);
      end else begin
        for (int j = 0; j < len; j++) push_byte(plain_byte());
      end
      if (k != nfields - 1) push_byte(phase_delim);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        push_byte(csvtok_pkg::CH_CR);
        push_byte(csvtok_pkg::CH_LF);
      end
      4, 5, 6: push_byte(csvtok_pkg::CH_LF);
      7, 8:    push_byte(csvtok_pkg::CH_CR);
      default: push_end(rand_byte());
    endcase
  endfunction

  // Queue raw noise: any byte, biased toward the structural ones
  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       push_byte(csvtok_pkg::CH_QUOTE);
        1:       push_byte(phase_delim);
        2:       push_byte(csvtok_pkg::CH_CR);
        3:       push_byte(csvtok_pkg::CH_LF);
        4:       push_end(rand_byte());
        default: push_byte(rand_byte());
      endcase
    end
  endfunction

  function automatic void queue_phase(int budget);
    int stop_at;
    stop_at = queued_bytes + budget;
    while (queued_bytes < stop_at) begin
      if ($urandom_range(0, 99) < 15) queue_noise();
      else queue_record();
    end
  endfunction

  // Edge cases under the reset delimiter
  function automatic void queue_directed();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(csvtok_pkg::CH_COMMA);
    push_byte("a");
    push_byte(csvtok_pkg::CH_QUOTE);   // quote in mid-field opens quotes
    push_byte("x");
    push_byte(csvtok_pkg::CH_QUOTE);   // doubled quote gives a literal quote
    push_byte(csvtok_pkg::CH_QUOTE);
    push_byte(csvtok_pkg::CH_QUOTE);   // single quote closes on the next byte
    push_byte(csvtok_pkg::CH_CR);
    push_byte(csvtok_pkg::CH_LF);      // swallowed after the line end
    push_byte(csvtok_pkg::CH_LF);      // second LF is a blank line
    push_byte(csvtok_pkg::CH_CR);
    push_byte(csvtok_pkg::CH_LF);
    push_byte(csvtok_pkg::CH_QUOTE);
    push_byte(csvtok_pkg::CH_CR);      // line end inside quotes is data
    push_byte(csvtok_pkg::CH_COMMA);   // delimiter inside quotes is data
    push_byte(csvtok_pkg::CH_QUOTE);
    push_end(8'hFF);                   // closes the record with a quote still pending
    push_end(8'h00);                   // nothing open, no token
    push_byte(csvtok_pkg::CH_QUOTE);
    push_byte("z");
    push_end(8'h5A);                   // unterminated quote
    push_byte(csvtok_pkg::CH_LF);
    push_end(8'h00);
  endfunction

  // Hold until every byte is taken and every token checked, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(logic [7:0] value);
    cfg_valid <= 1'b1;
    delimiter_char <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_delim = value;
    phase_delim = value;
  endtask

  // Sequence: reset, directed bytes, then random phases under several delimiters
  initial begin
    logic [7:0] delim_plan[8];
    delim_plan = '{8'h00, 8'hFF, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
                   csvtok_pkg::CH_LF, 8'h09, 8'h00, csvtok_pkg::CH_COMMA};
    delim_plan[6] = rand_byte();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    queue_phase(PHASE_BYTES);
    wait_idle();
    foreach (delim_plan[p]) begin
      write_delimiter(delim_plan[p]);
      queue_phase(PHASE_BYTES);
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Drive bytes from the queue; predict each transaction as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tokenize_byte(offered_item);
        in_gap = pick_gap(tx_calm);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          offered_item = byte_queue.pop_front();
          in_valid <= 1'b1;
          byte_in <= offered_item.text;
          end_of_input <= offered_item.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each token transaction against the oldest prediction and pace out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token kind", int'(token_kind), 0);
        end else begin
          want_token = expected_tokens.pop_front();
          if (token_kind !== want_token.kind) begin
            report_mismatch("token_kind", int'(token_kind), int'(want_token.kind));
          end
          if (data_byte !== want_token.data) begin
            report_mismatch("data_byte", int'(data_byte), int'(want_token.data));
          end
        end
        tokens_seen++;
        // long hold-off lets the block fill up and stall its input
        if (tokens_seen == 300 || tokens_seen == 1100) out_hold = HOLD_CYCLES;
        else out_stall = pick_gap(rx_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

FILE: filelist.f
rtl/core/csvtok_pkg.sv
rtl/core/csvtok_step.sv
rtl/core/csvtok_obuf.sv
rtl/core/csv_byte_tokenizer_core.sv
tb/tb_csv_byte_tokenizer_core.sv
